// File: hw/rtl/lfsp_pkg.sv
// Package for the line follower steering and PWM block.
// Widths, register indexes, reset values, lookup tables and shared types.
// No dependencies.
package lfsp_pkg;

  // Field widths
  localparam int SENS_W   = 9;
  localparam int POS_W    = 4;
  localparam int WIDTH_W  = 6;
  localparam int DUTY_W   = 7;
  localparam int MCNT_W   = 8;
  localparam int SCNT_W   = 10;
  localparam int CFG_DW   = 10;
  localparam int CFG_AW   = 2;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_SERVO_CENTER = 2'd0;
  localparam logic [CFG_AW-1:0] REG_RIGHT_DUTY   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MOTOR_PERIOD = 2'd2;
  localparam logic [CFG_AW-1:0] REG_SERVO_PERIOD = 2'd3;

  // Register reset values
  localparam logic [WIDTH_W-1:0] RST_SERVO_CENTER = 6'd16;
  localparam logic [MCNT_W-1:0]  RST_RIGHT_DUTY   = 8'd100;
  localparam logic [MCNT_W-1:0]  RST_MOTOR_PERIOD = 8'd100;
  localparam logic [SCNT_W-1:0]  RST_SERVO_PERIOD = 10'd300;

  // Depth of the result queue
  localparam int OBUF_DEPTH = 2;

  typedef struct packed {
    logic [WIDTH_W-1:0] servo_center;
    logic [MCNT_W-1:0]  right_duty;
    logic [MCNT_W-1:0]  motor_period;
    logic [SCNT_W-1:0]  servo_period;
  } cfg_t;

  typedef struct packed {
    logic               left_drive;
    logic               right_drive;
    logic               servo_pulse;
    logic [POS_W-1:0]   line_position;
    logic [WIDTH_W-1:0] servo_width;
    logic [DUTY_W-1:0]  left_duty;
  } result_t;

  // Single lit sensor or adjacent pair -> position 1..9, else 0
  function automatic logic [POS_W-1:0] decode_pos(input logic [SENS_W-1:0] s);
    logic [POS_W-1:0] p;
    case (s)
      9'h001:                 p = 4'd1;
      9'h002, 9'h003:         p = 4'd2;
      9'h004, 9'h006:         p = 4'd3;
      9'h008, 9'h00C:         p = 4'd4;
      9'h010, 9'h018, 9'h030: p = 4'd5;
      9'h020, 9'h060:         p = 4'd6;
      9'h040, 9'h0C0:         p = 4'd7;
      9'h080, 9'h180:         p = 4'd8;
      9'h100:                 p = 4'd9;
      default:                p = 4'd0;
    endcase
    return p;
  endfunction

  // Left motor duty by position
  function automatic logic [DUTY_W-1:0] duty_lut(input logic [POS_W-1:0] p);
    logic [DUTY_W-1:0] d;
    case (p)
      4'd2:    d = 7'd60;
      4'd3:    d = 7'd40;
      4'd5:    d = 7'd85;
      4'd7:    d = 7'd35;
      4'd8:    d = 7'd45;
      4'd9:    d = 7'd55;
      default: d = 7'd50;
    endcase
    return d;
  endfunction

  // Servo offset around center by position
  function automatic logic signed [3:0] offset_lut(input logic [POS_W-1:0] p);
    logic signed [3:0] o;
    case (p)
      4'd1, 4'd2: o = -4'sd5;
      4'd3:       o = -4'sd3;
      4'd4:       o = -4'sd2;
      4'd6:       o = 4'sd1;
      4'd7:       o = 4'sd2;
      4'd8:       o = 4'sd3;
      4'd9:       o = 4'sd4;
      default:    o = 4'sd0;
    endcase
    return o;
  endfunction

endpackage

// File: hw/rtl/lfsp_if.sv
// Valid/ready channel interfaces for sensor items and result items.
// Depends on lfsp_pkg.
interface lfsp_in_if import lfsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SENS_W-1:0] sensors;
  logic              motor_tick;
  logic              servo_tick;

  modport source (output valid, sensors, motor_tick, servo_tick, input ready);
  modport sink   (input valid, sensors, motor_tick, servo_tick, output ready);
endinterface

interface lfsp_out_if import lfsp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               left_drive;
  logic               right_drive;
  logic               servo_pulse;
  logic [POS_W-1:0]   line_position;
  logic [WIDTH_W-1:0] servo_width;
  logic [DUTY_W-1:0]  left_duty;

  modport source (output valid, left_drive, right_drive, servo_pulse, line_position,
                  servo_width, left_duty, input ready);
  modport sink   (input valid, left_drive, right_drive, servo_pulse, line_position,
                  servo_width, left_duty, output ready);
endinterface

// File: hw/rtl/lfsp_core.sv
// Position decode, steering/duty lookup and PWM counters for one item.
// Updates held state on each accepted transaction. Depends on lfsp_pkg.
module lfsp_core import lfsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [SENS_W-1:0] sensors,
  input  logic              motor_tick,
  input  logic              servo_tick,
  input  cfg_t              cfg,
  output result_t           res
);

  logic [POS_W-1:0]  held_pos_r, held_pos_nxt;
  logic [MCNT_W-1:0] mcnt_r, mcnt_nxt, mcnt_inc;
  logic [SCNT_W-1:0] scnt_r, scnt_nxt, scnt_inc;
  logic              left_r, left_nxt;
  logic              right_r, right_nxt;
  logic              spulse_r, spulse_nxt;
  logic [POS_W-1:0]  pos;
  logic signed [7:0] width_raw;
  logic [WIDTH_W-1:0] width;
  logic [DUTY_W-1:0] lduty;

  // Position hold: unrecognized patterns keep the last one
  assign pos          = decode_pos(sensors);
  assign held_pos_nxt = (pos != '0) ? pos : held_pos_r;

  // Steering width with saturation, and left duty
  assign width_raw = $signed({2'b00, cfg.servo_center}) + 8'(offset_lut(held_pos_nxt));
  assign lduty     = duty_lut(held_pos_nxt);
  always_comb begin
    if (width_raw < 0) begin
      width = '0;
    end else if (width_raw > 8'sd63) begin
      width = '1;
    end else begin
      width = width_raw[WIDTH_W-1:0];
    end
  end

  // Motor counter and levels
  always_comb begin
    mcnt_inc  = mcnt_r + 1'b1;
    mcnt_nxt  = mcnt_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    if (motor_tick) begin
      mcnt_nxt  = (mcnt_inc == cfg.motor_period) ? '0 : mcnt_inc;
      left_nxt  = (mcnt_nxt <= {1'b0, lduty});
      right_nxt = (mcnt_nxt <= cfg.right_duty);
    end
  end

  // Servo counter and pulse level
  always_comb begin
    scnt_inc   = scnt_r + 1'b1;
    scnt_nxt   = scnt_r;
    spulse_nxt = spulse_r;
    if (servo_tick) begin
      scnt_nxt   = (scnt_inc == cfg.servo_period) ? '0 : scnt_inc;
      spulse_nxt = (scnt_nxt < {4'b0000, width});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_pos_r <= '0;
      mcnt_r     <= '0;
      scnt_r     <= '0;
      left_r     <= 1'b0;
      right_r    <= 1'b0;
      spulse_r   <= 1'b0;
    end else if (acc) begin
      held_pos_r <= held_pos_nxt;
      mcnt_r     <= mcnt_nxt;
      scnt_r     <= scnt_nxt;
      left_r     <= left_nxt;
      right_r    <= right_nxt;
      spulse_r   <= spulse_nxt;
    end
  end

  // Result for the transaction being accepted
  always_comb begin
    res.left_drive    = left_nxt;
    res.right_drive   = right_nxt;
    res.servo_pulse   = spulse_nxt;
    res.line_position = held_pos_nxt;
    res.servo_width   = width;
    res.left_duty     = lduty;
  end

endmodule

// File: hw/rtl/lfsp_obuf.sv
// Small result queue that decouples the input and result handshakes.
// Depends on lfsp_pkg.
module lfsp_obuf import lfsp_pkg::*; #(
  parameter int DEPTH = OBUF_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  result_t wr_data,
  output logic    full,
  output logic    rd_valid,
  input  logic    rd_en,
  output result_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  result_t            slot_r [DEPTH];
  logic [PW-1:0]      wptr_r, rptr_r;
  logic [$clog2(DEPTH+1)-1:0] cnt_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (cnt_r == ($bits(cnt_r))'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = slot_r[rptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wptr_r] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr_en) begin
        wptr_r <= ptr_inc(wptr_r);
      end
      if (rd_en) begin
        rptr_r <= ptr_inc(rptr_r);
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: hw/rtl/line_follower_steer_and_pwm.sv
// Line follower steering and motor/servo PWM, top level.
// Results are offered from a two-entry result queue, not straight from the core.
// Throughput: one transaction per cycle while the queue is not full; it keeps input
// open while one result waits. All per-item work is one combinational pass.
// Reset: synchronous, active low; clears held position, counters, levels,
// the result queue and loads the register reset values.
module line_follower_steer_and_pwm import lfsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  lfsp_in_if.sink           in_ch,
  lfsp_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  cfg_t    cfg_r;
  result_t res;
  result_t q_data;
  logic    acc;
  logic    q_full;
  logic    q_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.servo_center <= RST_SERVO_CENTER;
      cfg_r.right_duty   <= RST_RIGHT_DUTY;
      cfg_r.motor_period <= RST_MOTOR_PERIOD;
      cfg_r.servo_period <= RST_SERVO_PERIOD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SERVO_CENTER: cfg_r.servo_center <= cfg_data[WIDTH_W-1:0];
        REG_RIGHT_DUTY:   cfg_r.right_duty   <= cfg_data[MCNT_W-1:0];
        REG_MOTOR_PERIOD: cfg_r.motor_period <= cfg_data[MCNT_W-1:0];
        REG_SERVO_PERIOD: cfg_r.servo_period <= cfg_data[SCNT_W-1:0];
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;

  lfsp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .sensors    (in_ch.sensors),
    .motor_tick (in_ch.motor_tick),
    .servo_tick (in_ch.servo_tick),
    .cfg        (cfg_r),
    .res        (res)
  );

  lfsp_obuf #(.DEPTH(OBUF_DEPTH)) u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (acc),
    .wr_data  (res),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_en    (q_valid && out_ch.ready),
    .rd_data  (q_data)
  );

  // Result channel
  assign out_ch.valid         = q_valid;
  assign out_ch.left_drive    = q_data.left_drive;
  assign out_ch.right_drive   = q_data.right_drive;
  assign out_ch.servo_pulse   = q_data.servo_pulse;
  assign out_ch.line_position = q_data.line_position;
  assign out_ch.servo_width   = q_data.servo_width;
  assign out_ch.left_duty     = q_data.left_duty;

endmodule

// File: hw/rtl/lfsp_checker.sv
// Port-level checks for the line follower block, bound to the top level.
// Depends on lfsp_pkg and line_follower_steer_and_pwm.
module lfsp_checker import lfsp_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic [POS_W-1:0]   out_line_position,
  input logic [DUTY_W-1:0]  out_left_duty
);

  // Nothing offered right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // Input only stalls while results are pending
  a_stall_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // A result is offered in the cycle after a transaction is accepted
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted transaction produced no result");

  // Held position in range and left duty follows it
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_line_position <= 4'd9))
    else $error("line position out of range");

  a_duty_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_duty == duty_lut(out_line_position)))
    else $error("left duty does not match line position");

endmodule

bind line_follower_steer_and_pwm lfsp_checker u_lfsp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_line_position (out_ch.line_position),
  .out_left_duty     (out_ch.left_duty)
);

// File: test/line_follower_steer_and_pwm_tb.sv
// Testbench for line_follower_steer_and_pwm: sensor transactions in, pin/steer results out.
// Depends on lfsp_pkg, lfsp_in_if/lfsp_out_if and the line_follower_steer_and_pwm RTL.
`timescale 1ns / 1ps

module line_follower_steer_and_pwm_tb import lfsp_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_LEN       = 120;
  localparam int MAX_REPORTS    = 10;

  // Servo offset and left duty by held position 0..9
  localparam int STEER_OFFSET [10] = '{0, -5, -5, -3, -2, 0, 1, 2, 3, 4};
  localparam int LEFT_DUTY_TAB [10] = '{50, 50, 60, 40, 50, 85, 50, 35, 45, 55};

  // Every sensor pattern that maps to a line position
  localparam logic [SENS_W-1:0] LINE_MARKS [17] = '{
    9'h001, 9'h002, 9'h003, 9'h004, 9'h006, 9'h008, 9'h00C, 9'h010, 9'h018,
    9'h030, 9'h020, 9'h060, 9'h040, 9'h0C0, 9'h080, 9'h180, 9'h100};

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  lfsp_in_if  in_ch ();
  lfsp_out_if out_ch ();

  line_follower_steer_and_pwm dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state and register copy
  cfg_t               ctl;
  logic [POS_W-1:0]   held_pos;
  logic [MCNT_W-1:0]  motor_cnt;
  logic [SCNT_W-1:0]  servo_cnt;
  logic               left_lvl, right_lvl, servo_lvl;
  result_t            pin_expect_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int failures = 0;
  int hold_requests;

  // Single lit sensor -> its index + 1; adjacent pair -> table by lower index; else 0
  function automatic logic [POS_W-1:0] line_pos_of(input logic [SENS_W-1:0] s);
    int pair_pos [8] = '{2, 3, 4, 5, 5, 6, 7, 8};
    int lo;
    lo = 0;
    for (int b = SENS_W - 1; b >= 0; b--)
      if (s[b]) lo = b;
    if ($countones(s) == 1) return POS_W'(lo + 1);
    if ($countones(s) == 2 && (s & (s >> 1)) != '0) return POS_W'(pair_pos[lo]);
    return '0;
  endfunction

  // Advance position, counters and pin levels for one transaction
  function automatic result_t step_pins(input logic [SENS_W-1:0] s, input logic mt,
                                        input logic st);
    logic [POS_W-1:0] pos;
    int               w;
    int               duty;
    result_t          r;
    pos = line_pos_of(s);
    if (pos != '0) held_pos = pos;
    w = int'(ctl.servo_center) + STEER_OFFSET[held_pos];
    if (w < 0) w = 0;
    if (w > 63) w = 63;
    duty = LEFT_DUTY_TAB[held_pos];
    if (mt) begin
      motor_cnt++;
      if (motor_cnt == ctl.motor_period) motor_cnt = '0;
      left_lvl  = (int'(motor_cnt) <= duty);
      right_lvl = (motor_cnt <= ctl.right_duty);
    end
    if (st) begin
      servo_cnt++;
      if (servo_cnt == ctl.servo_period) servo_cnt = '0;
      servo_lvl = (int'(servo_cnt) < w);
    end
    r.left_drive    = left_lvl;
    r.right_drive   = right_lvl;
    r.servo_pulse   = servo_lvl;
    r.line_position = held_pos;
    r.servo_width   = WIDTH_W'(w);
    r.left_duty     = DUTY_W'(duty);
    return r;
  endfunction

  // Offer one transaction, wait for acceptance, record its expected result
  task automatic send_sample(input logic [SENS_W-1:0] s, input logic mt, input logic st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.sensors    <= s;
    in_ch.motor_tick <= mt;
    in_ch.servo_tick <= st;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pin_expect_q.push_back(step_pins(s, mt, st));
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected result is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pin_expect_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_SERVO_CENTER: ctl.servo_center = val[WIDTH_W-1:0];
      REG_RIGHT_DUTY:   ctl.right_duty   = val[MCNT_W-1:0];
      REG_MOTOR_PERIOD: ctl.motor_period = val[MCNT_W-1:0];
      REG_SERVO_PERIOD: ctl.servo_period = val[SCNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_controls(input logic [CFG_DW-1:0] center, input logic [CFG_DW-1:0] rduty,
                              input logic [CFG_DW-1:0] mperiod,
                              input logic [CFG_DW-1:0] speriod);
    drain_results();
    write_reg(REG_SERVO_CENTER, center);
    write_reg(REG_RIGHT_DUTY, rduty);
    write_reg(REG_MOTOR_PERIOD, mperiod);
    write_reg(REG_SERVO_PERIOD, speriod);
  endtask

  // Mostly valid line patterns, the rest arbitrary sensor noise
  task automatic run_random_phase(input int n, input int tick_pct);
    logic [SENS_W-1:0] s;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 60) s = LINE_MARKS[$urandom_range(16)];
      else s = SENS_W'($urandom_range(511));
      send_sample(s, $urandom_range(99) < tick_pct, $urandom_range(99) < tick_pct);
    end
  endtask

  // All position patterns, no-line and broken patterns, all tick combinations
  task automatic test_line_positions();
    send_sample(9'h000, 1'b0, 1'b0);
    send_sample(9'h1FF, 1'b1, 1'b1);
    for (int i = 0; i < 17; i++)
      send_sample(LINE_MARKS[i], i[0], i[1]);
    send_sample(9'h005, 1'b1, 1'b0);
    send_sample(9'h0A0, 1'b0, 1'b1);
  endtask

  // Servo width clamps at 0 and 63
  task automatic test_width_saturation();
    set_controls(CFG_DW'(0), CFG_DW'(RST_RIGHT_DUTY), CFG_DW'(RST_MOTOR_PERIOD),
                 CFG_DW'(RST_SERVO_PERIOD));
    send_sample(9'h001, 1'b1, 1'b1);
    send_sample(9'h100, 1'b0, 1'b1);
    set_controls(CFG_DW'(63), CFG_DW'(RST_RIGHT_DUTY), CFG_DW'(RST_MOTOR_PERIOD),
                 CFG_DW'(RST_SERVO_PERIOD));
    send_sample(9'h100, 1'b1, 1'b1);
    send_sample(9'h001, 1'b0, 1'b1);
  endtask

  // Period zero: counters wrap at their width; run them high for the next test
  task automatic test_zero_periods();
    set_controls(CFG_DW'(20), CFG_DW'(255), CFG_DW'(0), CFG_DW'(0));
    run_random_phase(200, 100);
  endtask

  // Periods written below the running counts
  task automatic test_period_below_count();
    set_controls(CFG_DW'(63), CFG_DW'(0), CFG_DW'(40), CFG_DW'(60));
    run_random_phase(70, 100);
  endtask

  task automatic test_unit_periods();
    set_controls(CFG_DW'(0), CFG_DW'(128), CFG_DW'(1), CFG_DW'(1));
    run_random_phase(40, 50);
  endtask

  // Receiver holds off long enough for the block to stall its input
  task automatic test_result_backpressure();
    set_controls(CFG_DW'(5), CFG_DW'(30), CFG_DW'(100), CFG_DW'(1023));
    hold_requests++;
    run_random_phase(60, 50);
  endtask

  task automatic test_sender_pause();
    set_controls(CFG_DW'(58), CFG_DW'(77), CFG_DW'(255), CFG_DW'(20));
    run_random_phase(30, 60);
    drain_results();
    run_random_phase(30, 60);
  endtask

  task automatic test_random_settings();
    repeat (2) begin
      set_controls(CFG_DW'($urandom_range(63)), CFG_DW'($urandom_range(255)),
                   CFG_DW'($urandom_range(1, 255)), CFG_DW'($urandom_range(1, 64)));
      run_random_phase(35, 70);
    end
  endtask

  // Result receiver: random stalls plus requested long hold-offs
  initial begin
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.left_drive    = out_ch.left_drive;
      got.right_drive   = out_ch.right_drive;
      got.servo_pulse   = out_ch.servo_pulse;
      got.line_position = out_ch.line_position;
      got.servo_width   = out_ch.servo_width;
      got.left_duty     = out_ch.left_duty;
      if (pin_expect_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: result with none expected: %p", $realtime, got);
      end else begin
        want = pin_expect_q.pop_front();
        if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
            got.servo_pulse !== want.servo_pulse ||
            got.line_position !== want.line_position ||
            got.servo_width !== want.servo_width || got.left_duty !== want.left_duty) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
        end
      end
    end
  end

  // Watchdog: too long with no transaction on either channel
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("line_follower_steer_and_pwm test failed");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.sensors    = '0;
    in_ch.motor_tick = 1'b0;
    in_ch.servo_tick = 1'b0;
    hold_requests    = 0;
    send_idle_pct    = 15;
    recv_idle_pct    = 73;
    ctl.servo_center = RST_SERVO_CENTER;
    ctl.right_duty   = RST_RIGHT_DUTY;
    ctl.motor_period = RST_MOTOR_PERIOD;
    ctl.servo_period = RST_SERVO_PERIOD;
    held_pos         = '0;
    motor_cnt        = '0;
    servo_cnt        = '0;
    left_lvl         = 1'b0;
    right_lvl        = 1'b0;
    servo_lvl        = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_line_positions();
    test_width_saturation();
    test_zero_periods();
    test_period_below_count();

    send_idle_pct = 73;
    recv_idle_pct = 15;
    test_unit_periods();
    test_result_backpressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_sender_pause();
    test_random_settings();

    drain_results();
    repeat (4) @(negedge clk);
    if (failures == 0 && pin_expect_q.size() == 0)
      $display("line_follower_steer_and_pwm test passed");
    else
      $display("line_follower_steer_and_pwm test failed");
    $finish;
  end

endmodule
